// ----- rtl/core/sharpen_3x3_convolution_macros.svh -----
// Assertion macros shared by the sharpen filter RTL.
// Include with the bare file name; no other dependencies.
`ifndef SHARPEN_3X3_CONVOLUTION_MACROS_SVH
`define SHARPEN_3X3_CONVOLUTION_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SHARP3_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by a consequence on the next clock.
`define SHARP3_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sharp3_pkg.sv -----
// Types, register codes and the per-channel sharpen arithmetic for the
// 3x3 sharpen filter. No dependencies.
package sharp3_pkg;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // Decisions taken when an item is accepted, carried to the output stage.
   typedef struct packed {
      logic out_now;
      logic filter;
      logic last;
   } stage_ctrl_type;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

   localparam logic [7:0]         PIX_MAX = 8'd255;
   localparam logic signed [11:0] ACC_MAX = 12'sd255;

   // 5*center minus the up, down, left and right neighbors, clamped to 0..255.
   function automatic logic [7:0] sharpen_channel(input logic [7:0] center,
                                                  input logic [7:0] up,
                                                  input logic [7:0] down,
                                                  input logic [7:0] left,
                                                  input logic [7:0] right);
      logic signed [11:0] acc;
      logic [7:0]         res;
      // center*5 as center + center*4
      acc = $signed({4'b0, center}) + $signed({2'b0, center, 2'b0})
          - $signed({4'b0, up}) - $signed({4'b0, down})
          - $signed({4'b0, left}) - $signed({4'b0, right});
      if (acc < 12'sd0) begin
         res = 8'd0;
      end else if (acc > ACC_MAX) begin
         res = PIX_MAX;
      end else begin
         res = acc[7:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/sharpen_3x3_convolution.sv -----
// Streaming 3x3 sharpen filter for RGB888 frames in raster order.
// Depends on sharp3_pkg and sharpen_3x3_convolution_macros.svh.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   req_tdata pixel, req_tuser flush
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata pixel, rsp_tlast frame end
//   csr      in         csr_we                  csr_index, csr_wdata
//
// One item per clock sustained while rsp_tready stays high. A result passes from
// the stage register, fed by the registered read of the two line store memories,
// to the result register that drives rsp. Synchronous reset clears control and
// window state; the line stores are not cleared. While rsp_tready is low the
// result register and one item in the stage hold, then req_tready drops.
`include "sharpen_3x3_convolution_macros.svh"

module sharpen_3x3_convolution #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
   input  logic        req_tuser,   // flush [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = COL_W + 1;
   localparam int EXT_W = (CNT_W > 12) ? CNT_W : 12;

   // configuration
   logic [11:0] image_width_ff, image_width_in;
   logic [15:0] image_height_ff, image_height_in;
   logic [EXT_W-1:0] width_raw;
   logic [EXT_W-1:0] width_cap;
   logic [CNT_W-1:0] width_eff;
   logic [15:0]      height_eff;

   // input position
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [15:0]      row_count_ff, row_count_in;
   logic [CNT_W-1:0] pending_count_ff, pending_count_in;

   // handshake
   logic req_accept, load_s1, s1_fire, out_free, draining, flush;
   logic [CNT_W-1:0] col_plus;
   logic             border, drain_last;

   // stage register
   logic                       s1_valid_ff, s1_valid_in;
   sharp3_pkg::stage_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   sharp3_pkg::pixel_type      s1_pixel_ff, s1_pixel_in;
   logic [COL_W-1:0]           s1_col_ff;

   // line stores and forwarding
   sharp3_pkg::pixel_type upper_store_ff  [MAX_WIDTH];
   sharp3_pkg::pixel_type middle_store_ff [MAX_WIDTH];
   sharp3_pkg::pixel_type upper_q_ff, middle_q_ff;
   logic                  bypass_ff, bypass_in;
   sharp3_pkg::pixel_type byp_upper_ff, byp_middle_ff;
   sharp3_pkg::pixel_type up_used, mid_used;

   // window: top, middle left, center, bottom
   sharp3_pkg::pixel_type win_tr_ff, win_c_ff, win_mr_ff, win_br_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   sharp3_pkg::pixel_type rsp_pixel_ff, rsp_pixel_in;
   logic                  rsp_last_ff;

   assign width_raw  = EXT_W'(image_width_ff);
   assign width_cap  = EXT_W'(MAX_WIDTH);
   assign width_eff  = (width_raw == '0) ? CNT_W'(1) :
                       (width_raw > width_cap) ? CNT_W'(MAX_WIDTH) : CNT_W'(width_raw);
   assign height_eff = (image_height_ff == 16'd0) ? 16'd1 : image_height_ff;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         case (csr_index)
            sharp3_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata[11:0];
            sharp3_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign draining   = row_count_ff >= height_eff;
   assign flush      = req_tuser;
   // drop a flush while pixels are still expected
   assign load_s1    = req_accept && (draining || !flush);

   assign col_plus   = {1'b0, column_count_ff} + CNT_W'(1);
   assign drain_last = pending_count_ff >= width_eff;
   assign border     = (column_count_ff == '0) || (column_count_ff == COL_W'(1)) ||
                       (row_count_ff <= 16'd1) || ({1'b0, column_count_ff} >= width_eff);

   always_comb begin
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      pending_count_in = pending_count_ff;
      s1_ctrl_in       = '0;
      s1_pixel_in      = '0;
      if (draining) begin
         s1_ctrl_in.out_now = !((height_eff == 16'd1) && (pending_count_ff == '0));
         s1_ctrl_in.last    = drain_last;
      end else begin
         s1_ctrl_in.out_now = (row_count_ff >= 16'd2) ||
                              ((row_count_ff == 16'd1) && (column_count_ff != '0));
         s1_ctrl_in.filter  = !border;
         s1_pixel_in        = req_tdata;
      end
      if (load_s1) begin
         if (draining) begin
            if (drain_last) begin
               column_count_in  = '0;
               row_count_in     = '0;
               pending_count_in = '0;
            end else begin
               pending_count_in = pending_count_ff + CNT_W'(1);
               column_count_in  = (col_plus >= width_eff) ? '0 : col_plus[COL_W-1:0];
            end
         end else if (col_plus >= width_eff) begin
            column_count_in = '0;
            row_count_in    = row_count_ff + 16'd1;
            if (row_count_in >= height_eff) begin
               pending_count_in = '0;
            end
         end else begin
            column_count_in = col_plus[COL_W-1:0];
         end
      end
   end

   assign s1_valid_in = load_s1 ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   // the item leaving this cycle writes the column the new item reads
   assign bypass_in   = s1_fire && (s1_col_ff == column_count_ff);

   assign up_used  = bypass_ff ? byp_upper_ff  : upper_q_ff;
   assign mid_used = bypass_ff ? byp_middle_ff : middle_q_ff;

   always_comb begin
      rsp_pixel_in = win_mr_ff;
      if (s1_ctrl_ff.filter) begin
         rsp_pixel_in.red   = sharp3_pkg::sharpen_channel(win_mr_ff.red, win_tr_ff.red,
                                 win_br_ff.red, win_c_ff.red, mid_used.red);
         rsp_pixel_in.green = sharp3_pkg::sharpen_channel(win_mr_ff.green, win_tr_ff.green,
                                 win_br_ff.green, win_c_ff.green, mid_used.green);
         rsp_pixel_in.blue  = sharp3_pkg::sharpen_channel(win_mr_ff.blue, win_tr_ff.blue,
                                 win_br_ff.blue, win_c_ff.blue, mid_used.blue);
      end
   end

   assign rsp_valid_in = (s1_fire && s1_ctrl_ff.out_now) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= sharp3_pkg::IMAGE_WIDTH_RESET;
         image_height_ff  <= sharp3_pkg::IMAGE_HEIGHT_RESET;
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         pending_count_ff <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         win_tr_ff        <= '0;
         win_c_ff         <= '0;
         win_mr_ff        <= '0;
         win_br_ff        <= '0;
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         pending_count_ff <= pending_count_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (s1_fire) begin
            win_c_ff  <= win_mr_ff;
            win_tr_ff <= up_used;
            win_mr_ff <= mid_used;
            win_br_ff <= s1_pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_ctrl_ff    <= s1_ctrl_in;
         s1_pixel_ff   <= s1_pixel_in;
         s1_col_ff     <= column_count_ff;
         bypass_ff     <= bypass_in;
         byp_upper_ff  <= mid_used;
         byp_middle_ff <= s1_pixel_ff;
      end
      if (s1_fire && s1_ctrl_ff.out_now) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_last_ff  <= s1_ctrl_ff.last;
      end
   end

   // line stores: read at accept, write when the item leaves the stage
   always_ff @(posedge clock) begin
      if (load_s1) begin
         upper_q_ff  <= upper_store_ff[column_count_ff];
         middle_q_ff <= middle_store_ff[column_count_ff];
      end
      if (s1_fire) begin
         upper_store_ff[s1_col_ff]  <= mid_used;
         middle_store_ff[s1_col_ff] <= s1_pixel_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SHARP3_ASSERT(a_rsp_from_stage, clock, reset,
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff), "result appeared without a staged item")
   `SHARP3_ASSERT(a_stall_blocks_input, clock, reset,
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready,
      "input taken while stage and result register are both blocked")
   `SHARP3_ASSERT_NEXT(a_frame_restart, clock, reset,
      load_s1 && draining && drain_last,
      (row_count_ff == 16'd0) && (column_count_ff == '0) && (pending_count_ff == '0),
      "frame position not cleared after the last drain step")

endmodule

// ----- test/sharpen_3x3_convolution_tb.sv -----
// Self-checking testbench for the streaming 3x3 sharpen filter: a local model of the
// line stores and window predicts every output pixel, and a checker compares each result.
// Depends on sharp3_pkg and the sharpen_3x3_convolution RTL.
module sharpen_3x3_convolution_tb;

   localparam int LINE_DEPTH   = 2048;
   localparam int SETTLE_TICKS = 6;
   localparam int MAX_REPORTS  = 10;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_type;

   typedef struct {
      sharp3_pkg::pixel_type pix;
      logic                  last;
   } out_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // red_in [7:0], green_in [15:8], blue_in [23:16]
   logic        req_tuser  = 1'b0; // flush [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // red_out [7:0], green_out [15:8], blue_out [23:16]
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_wdata  = '0;

   sharpen_3x3_convolution #(.MAX_WIDTH(LINE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Local copy of the filter state
   logic [23:0] row_above_mem [LINE_DEPTH];
   logic [23:0] row_middle_mem[LINE_DEPTH];
   logic [23:0] taps[9];
   int unsigned col_pos, row_pos, drain_steps;
   logic [11:0] width_reg;
   logic [15:0] height_reg;

   out_beat_type expected_pixels[$];
   int          frames_done    = 0;
   int          items_counted  = 0;
   int          results_checked = 0;
   int          mismatch_count = 0;
   int          burst_left     = 0;
   int          max_gap        = 4;
   rx_mode_type stall_mode     = RX_ALWAYS;
   int          rx_phase       = 0;

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic logic [7:0] sharpen_lane(input int lane);
      int acc;
      acc = 5 * int'(taps[4][lane*8 +: 8]) - int'(taps[1][lane*8 +: 8])
          - int'(taps[7][lane*8 +: 8]) - int'(taps[3][lane*8 +: 8])
          - int'(taps[5][lane*8 +: 8]);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return acc[7:0];
   endfunction

   function automatic void push_center(input bit filt, input bit last);
      out_beat_type beat;
      int           lane;
      beat.pix = taps[4];
      if (filt) begin
         for (lane = 0; lane < 3; lane++) beat.pix[lane*8 +: 8] = sharpen_lane(lane);
      end
      beat.last = last;
      expected_pixels.push_back(beat);
   endfunction

   function automatic void clear_filter_state();
      int i;
      for (i = 0; i < LINE_DEPTH; i++) begin
         row_above_mem[i]  = '0;
         row_middle_mem[i] = '0;
      end
      for (i = 0; i < 9; i++) taps[i] = '0;
      col_pos     = 0;
      row_pos     = 0;
      drain_steps = 0;
      width_reg   = sharp3_pkg::IMAGE_WIDTH_RESET;
      height_reg  = sharp3_pkg::IMAGE_HEIGHT_RESET;
   endfunction

   // Advance the local filter by one accepted item; return 0 when the item is dropped.
   function automatic bit advance_filter(input logic [23:0] data, input logic flush);
      int unsigned w, h, c, d;
      logic [23:0] px, up, mid;
      bit          draining, out_now, last, border;
      int          orow, ocol;
      w = eff_width();
      h = eff_height();
      draining = (row_pos >= h);
      c = col_pos;
      px = '0;
      if (!draining && flush) return 1'b0;
      if (!draining) px = data;
      if (c >= LINE_DEPTH) c = 0;
      up  = row_above_mem[c];
      mid = row_middle_mem[c];
      row_above_mem[c]  = mid;
      row_middle_mem[c] = px;
      taps[0] = taps[1]; taps[1] = taps[2]; taps[2] = up;
      taps[3] = taps[4]; taps[4] = taps[5]; taps[5] = mid;
      taps[6] = taps[7]; taps[7] = taps[8]; taps[8] = px;
      if (draining) begin
         d = drain_steps;
         last = (d >= w);
         out_now = !(h == 1 && d == 0);
         if (out_now) push_center(1'b0, last);
         if (last) begin
            col_pos = 0;
            row_pos = 0;
            drain_steps = 0;
            frames_done++;
         end else begin
            drain_steps = d + 1;
            col_pos = (c + 1 >= w) ? 0 : c + 1;
         end
         return 1'b1;
      end
      out_now = (row_pos >= 2) || (row_pos == 1 && c >= 1);
      if (out_now) begin
         if (c >= 1) begin
            orow = int'(row_pos) - 1;
            ocol = int'(c) - 1;
         end else begin
            orow = int'(row_pos) - 2;
            ocol = int'(w) - 1;
         end
         border = orow <= 0 || orow >= int'(h) - 1 || ocol <= 0 || ocol >= int'(w) - 1;
         push_center(!border, 1'b0);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = row_pos + 1;
         if (row_pos >= h) drain_steps = 0;
      end else begin
         col_pos = c + 1;
      end
      return 1'b1;
   endfunction

   // Receiver stalls on its own pattern
   always @(posedge clock) begin
      rx_phase <= rx_phase + 1;
      case (stall_mode)
         RX_ALWAYS: rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:   rsp_tready <= (rx_phase % 29) >= 9;
      endcase
   end

   // Compare every output transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         out_beat_type          want;
         sharp3_pkg::pixel_type got;
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: unexpected result pixel %h last %b", $realtime, rsp_tdata,
                        rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (got.red !== want.pix.red || got.green !== want.pix.green ||
                got.blue !== want.pix.blue || rsp_tlast !== want.last) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: result %0d expected r%h g%h b%h last %b, got r%h g%h b%h last %b",
                           $realtime, results_checked, want.pix.red, want.pix.green,
                           want.pix.blue, want.last, got.red, got.green, got.blue, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_item(input logic [23:0] data, input logic flush);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= flush;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (advance_filter(data, flush)) items_counted++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if (max_gap > 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge clock);
         end
      end
   endtask

   // Hold off the sender until every predicted result has arrived
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == sharp3_pkg::CSR_IMAGE_WIDTH) width_reg = value[11:0];
      else height_reg = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] random_pixel();
      logic [23:0] px;
      int          lane;
      px = 24'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         for (lane = 0; lane < 3; lane++)
            px[lane*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return px;
   endfunction

   // Send pixels until the frame is complete, then drain it to its last result
   task automatic finish_frame(input int noise_pct);
      int start;
      start = frames_done;
      while (row_pos < eff_height()) begin
         if ($urandom_range(0, 99) < noise_pct) send_item(random_pixel(), 1'b1);
         send_item(random_pixel(), 1'b0);
      end
      while (frames_done == start) begin
         if ($urandom_range(0, 99) < noise_pct) send_item(random_pixel(), 1'b0);
         else send_item(24'($urandom), 1'b1);
      end
   endtask

   task automatic test_tiny_frames();
      // zero sizes fall back to 1x1; upper width bits are dropped
      write_reg(sharp3_pkg::CSR_IMAGE_WIDTH, 16'hF000);
      write_reg(sharp3_pkg::CSR_IMAGE_HEIGHT, 16'h0000);
      send_item(24'hFFFFFF, 1'b1);   // flush before the pixel: dropped
      send_item(24'hFFFFFF, 1'b0);
      send_item(24'h000000, 1'b1);
      send_item(24'h5A5A5A, 1'b0);   // pixel while draining acts as flush
      send_item(24'h000000, 1'b0);
      send_item(24'h000000, 1'b1);
      send_item(24'hFFFFFF, 1'b0);
      send_item(24'hA5A5A5, 1'b1);
      send_item(24'h123456, 1'b1);
      wait_idle();
   endtask

   task automatic test_clamp_limits();
      sharp3_pkg::pixel_type center, edge_px;
      int                    i;
      center  = '{blue: 8'h30, green: 8'h00, red: 8'hFF};
      edge_px = '{blue: 8'h10, green: 8'hFF, red: 8'h00};
      write_reg(sharp3_pkg::CSR_IMAGE_WIDTH, 16'd3);
      write_reg(sharp3_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      for (i = 0; i < 9; i++) begin
         if (i == 4) send_item(center, 1'b0);
         else if (i % 2 == 1) send_item(edge_px, 1'b0);
         else send_item(24'($urandom), 1'b0);
      end
      finish_frame(0);
      wait_idle();
   endtask

   task automatic test_resize_in_frame();
      int i;
      stall_mode = RX_RANDOM;
      write_reg(sharp3_pkg::CSR_IMAGE_WIDTH, 16'd8);
      write_reg(sharp3_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      finish_frame(0);
      wait_idle();
      // tallest height, then shrink width and height inside the frame
      write_reg(sharp3_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
      for (i = 0; i < 19; i++) send_item(random_pixel(), 1'b0);
      wait_idle();
      write_reg(sharp3_pkg::CSR_IMAGE_WIDTH, 16'd5);
      for (i = 0; i < 9; i++) send_item(random_pixel(), 1'b0);
      wait_idle();
      write_reg(sharp3_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      finish_frame(0);
      wait_idle();
   endtask

   task automatic test_widest_rows();
      stall_mode = RX_RANDOM;
      write_reg(sharp3_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      // width beyond the line store saturates to the full row
      write_reg(sharp3_pkg::CSR_IMAGE_WIDTH, 16'h0FFF);
      finish_frame(0);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int          start;
      int unsigned w, h;
      start = items_counted;
      while (items_counted - start < 700) begin
         stall_mode = rx_mode_type'($urandom_range(0, 2));
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         // keep the sizes on some frames so frames run back to back
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 19))
               0:       w = $urandom_range(25, 64);
               1, 2:    w = 0;
               3, 4, 5: w = $urandom_range(9, 24);
               default: w = $urandom_range(1, 8);
            endcase
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            wait_idle();
            if ($urandom_range(0, 1))
               write_reg(sharp3_pkg::CSR_IMAGE_WIDTH, {4'($urandom), 12'(w)});
            write_reg(sharp3_pkg::CSR_IMAGE_HEIGHT, 16'(h));
         end
         finish_frame(6);
      end
      wait_idle();
   endtask

   initial begin
      clear_filter_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tiny_frames();
      test_clamp_limits();
      test_resize_in_frame();
      test_widest_rows();
      test_random_frames();
      stall_mode = RX_ALWAYS;
      wait_idle();
      if (expected_pixels.size() != 0) mismatch_count += expected_pixels.size();
      $display("Ran %0d frames with %0d pixel and drain transactions, %0d results checked.",
               frames_done, items_counted, results_checked);
      $display("Covered 1x1 and 2048-wide frames, width saturation and resizing mid-frame.");
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d results outstanding", expected_pixels.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sharpen_3x3_convolution.f -----
+incdir+rtl/core
rtl/core/sharp3_pkg.sv
rtl/core/sharpen_3x3_convolution.sv
test/sharpen_3x3_convolution_tb.sv
